// ----- rtl/core/pru_pkg.sv -----
package pru_pkg;

	localparam int PAGES     = 4096;
	localparam int PAGE_W    = 12;
	localparam int FRAMES    = 16;
	localparam int FIDX_W    = 4;
	localparam int SCAN_W    = FIDX_W + 1;
	localparam int ADDR_W    = 32;
	localparam int STAMP_W   = 32;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_POLICY = 2'd2;

	localparam logic [4:0] RESET_PAGE_SHIFT    = 5'd12;
	localparam logic [4:0] RESET_FRAMES_IN_USE = 5'd16;

	// page table entry: resident flag and frame
	localparam int PTE_W = 1 + FIDX_W;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              is_write;
	} access_t;

	typedef struct packed {
		logic               hit;
		logic [3:0]         frame_index;
		logic               evicted_valid;
		logic [11:0]        evicted_page;
		logic               out_of_range;
		logic [STAMP_W-1:0] fault_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_EVICT,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic               scan_clr;
		logic               scan_step;
		logic               policy;
		logic               touch;
		logic               install;
		logic [FIDX_W-1:0]  frame;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
	} fu_cmd_t;

	typedef struct packed {
		logic [SCAN_W-1:0] idx;
		logic              cur_free;
		logic [FIDX_W-1:0] best_nxt;
		logic [PAGE_W-1:0] owner;
	} fu_stat_t;

endpackage

// ----- rtl/core/pru_ram.sv -----
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- rtl/core/pru_frame_unit.sv -----
module pru_frame_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  pru_pkg::fu_cmd_t  cmd,
	output pru_pkg::fu_stat_t stat
);
	import pru_pkg::*;

	logic [FRAMES-1:0]  occ_q;
	logic [PAGE_W-1:0]  owner_q [FRAMES];
	logic [STAMP_W-1:0] last_q  [FRAMES];
	logic [STAMP_W-1:0] load_q  [FRAMES];

	logic [SCAN_W-1:0]  idx_q;
	logic [FIDX_W-1:0]  best_q;
	logic [STAMP_W-1:0] best_key_q;

	logic [FIDX_W-1:0]  sel;
	logic [STAMP_W-1:0] key;
	logic               take;

	// one comparator shared over the scan, one frame per cycle
	always_comb begin
		sel  = idx_q[FIDX_W-1:0];
		key  = cmd.policy ? load_q[sel] : last_q[sel];
		take = (idx_q == '0) || (key < best_key_q);
		stat.idx      = idx_q;
		stat.cur_free = !occ_q[sel];
		stat.best_nxt = take ? sel : best_q;
		stat.owner    = owner_q[cmd.frame];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.install) begin
				occ_q[cmd.frame] <= 1'b1;
			end
			if (cmd.scan_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + SCAN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && take) begin
			best_q     <= sel;
			best_key_q <= key;
		end
		if (cmd.install) begin
			owner_q[cmd.frame] <= cmd.page;
			load_q[cmd.frame]  <= cmd.stamp;
			last_q[cmd.frame]  <= cmd.stamp;
		end else if (cmd.touch) begin
			last_q[cmd.frame] <= cmd.stamp;
		end
	end

endmodule

// ----- rtl/core/page_replacement_unit.sv -----
// out-of-range accesses are answered from idle, hits after the look, misses after look,
// frame scan, eviction if no frame in use is free, and load; one item at a time, busy
// while an in-range item is worked on; the frame scan sets throughput, one frame entry
// per cycle through one comparator; a reset sweep clears the 4096-entry page table
// with busy high; done shows the result for one cycle; the receiver cannot stall
module page_replacement_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pru_pkg::access_t                  access,
	output logic                              done,
	output pru_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pru_pkg::CFG_W-1:0]         cfg_data
);
	import pru_pkg::*;

	state_t state_q, state_d;

	logic [4:0]         shift_q;
	logic [4:0]         fin_q;
	logic               pol_q;
	logic [PAGE_W-1:0]  clr_q;
	logic [PAGE_W-1:0]  page_q;
	logic [FIDX_W-1:0]  frame_q;
	logic               evict_q;
	logic [PAGE_W-1:0]  victim_q;
	logic [STAMP_W-1:0] clk_q;
	logic [STAMP_W-1:0] fault_q;
	logic               done_q;
	result_t            result_q;

	logic [ADDR_W-1:0]  page_full;
	logic               oor;
	logic [SCAN_W-1:0]  last_idx;

	logic               ram_we;
	logic [PAGE_W-1:0]  ram_addr;
	logic [PTE_W-1:0]   ram_wdata;
	logic [PTE_W-1:0]   ram_rdata;

	fu_cmd_t            fcmd;
	fu_stat_t           fstat;

	pru_ram #(
		.WIDTH(PTE_W),
		.DEPTH(PAGES)
	) u_page_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	pru_frame_unit u_frames (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (fcmd),
		.stat  (fstat)
	);

	assign page_full = access.address >> shift_q;
	assign oor       = page_full >= ADDR_W'(PAGES);

	// frames in use clamped to 1..FRAMES
	always_comb begin
		if (fin_q == '0) begin
			last_idx = '0;
		end else if (fin_q > SCAN_W'(FRAMES)) begin
			last_idx = SCAN_W'(FRAMES - 1);
		end else begin
			last_idx = fin_q - SCAN_W'(1);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = page_q;
		ram_wdata = '0;
		fcmd          = '0;
		fcmd.policy   = pol_q;
		fcmd.frame    = frame_q;
		fcmd.page     = page_q;
		fcmd.stamp    = clk_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_q == PAGE_W'(PAGES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ram_addr = page_full[PAGE_W-1:0];
				if (start && !oor) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (ram_rdata[PTE_W-1]) begin
					fcmd.touch = 1'b1;
					fcmd.frame = ram_rdata[FIDX_W-1:0];
					state_d    = ST_IDLE;
				end else begin
					fcmd.scan_clr = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				fcmd.scan_step = 1'b1;
				if (fstat.cur_free) begin
					state_d = ST_LOAD;
				end else if (fstat.idx == last_idx) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				// drop the victim page from the table
				ram_we   = 1'b1;
				ram_addr = fstat.owner;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				ram_we       = 1'b1;
				ram_wdata    = {1'b1, frame_q};
				fcmd.install = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= RESET_PAGE_SHIFT;
			fin_q   <= RESET_FRAMES_IN_USE;
			pol_q   <= 1'b0;
			clr_q   <= '0;
			clk_q   <= '0;
			fault_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_PAGE_SHIFT:     shift_q <= cfg_data;
					REG_FRAMES_IN_USE:  fin_q   <= cfg_data;
					REG_REPLACE_POLICY: pol_q   <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PAGE_W'(1);
				end
				ST_IDLE: begin
					if (start && oor) begin
						done_q <= 1'b1;
					end
				end
				ST_LOOK: begin
					if (ram_rdata[PTE_W-1]) begin
						clk_q  <= clk_q + STAMP_W'(1);
						done_q <= 1'b1;
					end else if (fault_q != '1) begin
						fault_q <= fault_q + STAMP_W'(1);
					end
				end
				ST_LOAD: begin
					clk_q  <= clk_q + STAMP_W'(1);
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				page_q  <= page_full[PAGE_W-1:0];
				evict_q <= 1'b0;
				if (start && oor) begin
					result_q               <= '0;
					result_q.out_of_range  <= 1'b1;
					result_q.fault_count   <= fault_q;
				end
			end
			ST_LOOK: begin
				if (ram_rdata[PTE_W-1]) begin
					result_q             <= '0;
					result_q.hit         <= 1'b1;
					result_q.frame_index <= ram_rdata[FIDX_W-1:0];
					result_q.fault_count <= fault_q;
				end
			end
			ST_SCAN: begin
				if (fstat.cur_free) begin
					frame_q <= fstat.idx[FIDX_W-1:0];
				end else begin
					frame_q <= fstat.best_nxt;
				end
			end
			ST_EVICT: begin
				evict_q  <= 1'b1;
				victim_q <= fstat.owner;
			end
			ST_LOAD: begin
				result_q.hit           <= 1'b0;
				result_q.frame_index   <= frame_q;
				result_q.evicted_valid <= evict_q;
				result_q.evicted_page  <= evict_q ? victim_q : '0;
				result_q.out_of_range  <= 1'b0;
				result_q.fault_count   <= fault_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a lookup is still running");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (!result.evicted_valid && !result.out_of_range))
		else $error("hit reported together with eviction or range error");

	a_fault_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (fault_q >= $past(fault_q)))
		else $error("fault count went backwards");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (fstat.idx <= last_idx))
		else $error("frame scan ran past the frames in use");
`endif

endmodule

// ----- tb/page_replacement_unit_tb.sv -----
`timescale 1ns / 100ps

module page_replacement_unit_tb;
	import pru_pkg::*;

	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES          = 8;
	localparam int DRAIN_CYCLES    = 25;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef enum logic {
		ROW_ACCESS,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_W-1:0]      value;
		access_t               item;
		logic                  typed;
		result_t               typed_result;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	access_t              access;
	logic                 done;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// typed expectation travels with the item it belongs to
	logic                 item_checked;
	result_t              item_expect;

	// predictor state
	logic                 resident_page [PAGES];
	logic [FIDX_W-1:0]    page_to_frame [PAGES];
	logic                 frame_taken [FRAMES];
	logic [PAGE_W-1:0]    frame_page [FRAMES];
	logic [STAMP_W-1:0]   frame_used_at [FRAMES];
	logic [STAMP_W-1:0]   frame_loaded_at [FRAMES];
	logic [STAMP_W-1:0]   access_tick;
	logic [STAMP_W-1:0]   fault_tally;
	logic [4:0]           cur_shift;
	logic [4:0]           cur_frames;
	logic                 cur_policy;

	result_t              pending_results [$];
	int                   in_flight = 0;
	int                   quiet_cycles = 0;
	int                   failures = 0;
	row_t                 directed_rows [$];

	logic [4:0] phase_shift  [PHASES] = '{5'd12, 5'd0, 5'd31, 5'd7, 5'd20, 5'd3, 5'd16, 5'd0};
	logic [4:0] phase_frames [PHASES] = '{5'd16, 5'd1, 5'd4, 5'd16, 5'd2, 5'd0, 5'd31, 5'd0};
	logic       phase_policy [PHASES] = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
		POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_LRU};
	int         phase_idle   [PHASES] = '{0, 75, 0, 25, 75, 0, 25, 0};

	page_replacement_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.access    (access),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < PAGES; i++) begin
			resident_page[i] = 1'b0;
			page_to_frame[i] = '0;
		end
		for (int i = 0; i < FRAMES; i++) begin
			frame_taken[i] = 1'b0;
			frame_page[i] = '0;
			frame_used_at[i] = '0;
			frame_loaded_at[i] = '0;
		end
		access_tick = '0;
		fault_tally = '0;
		cur_shift = RESET_PAGE_SHIFT;
		cur_frames = RESET_FRAMES_IN_USE;
		cur_policy = POLICY_LRU;
	end

	function automatic result_t predict_access(input access_t a);
		logic [31:0] pg;
		int          n;
		int          slot;
		result_t     r;
		r = '0;
		pg = a.address >> cur_shift;
		if (pg >= PAGES) begin
			r.out_of_range = 1'b1;
			r.fault_count = fault_tally;
			return r;
		end
		if (resident_page[pg]) begin
			r.hit = 1'b1;
			r.frame_index = page_to_frame[pg];
			frame_used_at[page_to_frame[pg]] = access_tick;
		end else begin
			if (fault_tally != '1)
				fault_tally++;
			n = int'(cur_frames);
			if (n < 1)
				n = 1;
			if (n > FRAMES)
				n = FRAMES;
			slot = -1;
			for (int i = 0; i < n; i++)
				if (!frame_taken[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				// every usable frame is full, pick a victim; ties keep the lower index
				slot = 0;
				for (int i = 1; i < n; i++) begin
					if (cur_policy == POLICY_FIFO) begin
						if (frame_loaded_at[i] < frame_loaded_at[slot])
							slot = i;
					end else begin
						if (frame_used_at[i] < frame_used_at[slot])
							slot = i;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page = frame_page[slot];
				resident_page[frame_page[slot]] = 1'b0;
			end
			frame_taken[slot] = 1'b1;
			frame_page[slot] = pg[PAGE_W-1:0];
			frame_loaded_at[slot] = access_tick;
			frame_used_at[slot] = access_tick;
			page_to_frame[pg] = slot[FIDX_W-1:0];
			resident_page[pg] = 1'b1;
			r.frame_index = slot[FIDX_W-1:0];
		end
		access_tick++;
		r.fault_count = fault_tally;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		logic    took;
		if (arst_n) begin
			took = start && !busy;
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no item outstanding: %0h", result);
					failures++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", 32'(want.hit), 32'(result.hit));
					check_field("frame_index", 32'(want.frame_index),
						32'(result.frame_index));
					check_field("evicted_valid", 32'(want.evicted_valid),
						32'(result.evicted_valid));
					check_field("evicted_page", 32'(want.evicted_page),
						32'(result.evicted_page));
					check_field("out_of_range", 32'(want.out_of_range),
						32'(result.out_of_range));
					check_field("fault_count", want.fault_count, result.fault_count);
				end
			end
			if (took) begin
				want = predict_access(access);
				pending_results.push_back(item_checked ? item_expect : want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PAGE_SHIFT:     cur_shift = cfg_data;
					REG_FRAMES_IN_USE:  cur_frames = cfg_data;
					REG_REPLACE_POLICY: cur_policy = cfg_data[0];
					default: ;
				endcase
			end
			in_flight <= pending_results.size();
			if (took || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("page_replacement_unit_tb failed");
				$finish;
			end
		end
	end

	// drop start and wait until the block has nothing in hand
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (in_flight != 0 || busy);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		if (!cfg_we)
			wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic send_access(input access_t a, input logic typed, input result_t typed_result,
		input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		access <= a;
		item_checked <= typed;
		item_expect <= typed_result;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_address(input logic [4:0] shift, input int page_base,
		input int span);
		logic [31:0] top_page;
		logic [31:0] low_mask;
		logic [31:0] pg;
		int          pick;
		top_page = 32'hFFFF_FFFF >> shift;
		// allow the first page past the table when the shift can reach it
		if (top_page > PAGES)
			top_page = PAGES;
		low_mask = (32'd1 << shift) - 32'd1;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom;
		if (pick < 25)
			pg = $urandom_range(top_page);
		else
			pg = (page_base + $urandom_range(span)) % (top_page + 1);
		return (pg << shift) | ($urandom & low_mask);
	endfunction

	function automatic row_t access_row(input logic [31:0] addr, input logic wr);
		row_t r;
		r.kind = ROW_ACCESS;
		r.index = '0;
		r.value = '0;
		r.item.address = addr;
		r.item.is_write = wr;
		r.typed = 1'b0;
		r.typed_result = '0;
		return r;
	endfunction

	function automatic row_t checked_row(input logic [31:0] addr, input logic wr,
		input result_t want);
		row_t r;
		r = access_row(addr, wr);
		r.typed = 1'b1;
		r.typed_result = want;
		return r;
	endfunction

	function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		row_t r;
		r = access_row('0, 1'b0);
		r.kind = ROW_WRITE;
		r.index = idx;
		r.value = v;
		return r;
	endfunction

	initial begin
		access_t    item;
		logic [4:0] shift;
		logic [4:0] frames;
		logic       policy;
		int         usable;
		int         page_base;
		int         span;

		arst_n <= 1'b0;
		start <= 1'b0;
		access <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_checked <= 1'b0;
		item_expect <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fields of typed rows: hit, frame, evicted valid, evicted page, out of range, faults
		directed_rows = {
			checked_row(32'h0000_0000, 1'b0, {1'b0, 4'd0, 1'b0, 12'd0, 1'b0, 32'd1}),
			checked_row(32'h0000_0FFF, 1'b1, {1'b1, 4'd0, 1'b0, 12'd0, 1'b0, 32'd1}),
			checked_row(32'hFFFF_FFFF, 1'b0, {1'b0, 4'd0, 1'b0, 12'd0, 1'b1, 32'd1}),
			checked_row(32'h00FF_FFFF, 1'b1, {1'b0, 4'd1, 1'b0, 12'd0, 1'b0, 32'd2}),
			checked_row(32'h0100_0000, 1'b0, {1'b0, 4'd0, 1'b0, 12'd0, 1'b1, 32'd2}),
			write_row(REG_FRAMES_IN_USE, 5'd2),
			access_row(32'h0000_1000, 1'b0),
			write_row(REG_REPLACE_POLICY, {4'd0, POLICY_FIFO}),
			access_row(32'h0000_0123, 1'b1),
			access_row(32'h0000_1ABC, 1'b0),
			write_row(REG_FRAMES_IN_USE, 5'd0),
			access_row(32'h0000_5000, 1'b1),
			// page held in a frame beyond the current count still hits
			access_row(32'h0000_0FFF, 1'b0),
			write_row(REG_FRAMES_IN_USE, 5'd31),
			write_row(REG_PAGE_SHIFT, 5'd0),
			access_row(32'h0000_0FFF, 1'b1),
			access_row(32'h0000_1000, 1'b0),
			write_row(REG_PAGE_SHIFT, 5'd31),
			access_row(32'h8000_0000, 1'b0),
			access_row(32'h7FFF_FFFF, 1'b1),
			write_row(REG_REPLACE_POLICY, {4'd0, POLICY_LRU}),
			access_row(32'hFFFF_FFFF, 1'b0)
		};
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_register(directed_rows[i].index, directed_rows[i].value);
			else
				send_access(directed_rows[i].item, directed_rows[i].typed,
					directed_rows[i].typed_result, 0);
		end

		for (int p = 0; p < PHASES; p++) begin
			shift = phase_shift[p];
			frames = phase_frames[p];
			policy = phase_policy[p];
			if (p == PHASES - 1) begin
				shift = 5'($urandom_range(31));
				frames = 5'($urandom_range(31));
				policy = 1'($urandom_range(1));
			end
			write_register(REG_PAGE_SHIFT, shift);
			write_register(REG_FRAMES_IN_USE, frames);
			write_register(REG_REPLACE_POLICY, {4'd0, policy});
			usable = (frames == 0) ? 1 : (frames > FRAMES) ? FRAMES : int'(frames);
			// working set about twice the usable frames so hits and evictions mix
			span = 2 * usable + 3;
			page_base = $urandom_range(PAGES - 1);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				item.address = random_address(shift, page_base, span);
				item.is_write = 1'($urandom_range(1));
				send_access(item, 1'b0, '0, phase_idle[p]);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			failures++;
		end
		if (failures == 0)
			$display("page_replacement_unit_tb passed");
		else
			$display("page_replacement_unit_tb failed");
		$finish;
	end

endmodule
